// ===== hw/rtl/frts_pkg.sv =====
// Shared constants for the frame ring timestamp selector.
package frts_pkg;

  localparam int RING_SIZE = 16;
  localparam int HEADROOM  = 4;
  localparam int SLOT_W    = $clog2(RING_SIZE);
  localparam int CNT_W     = $clog2(RING_SIZE) + 1;

  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_CONS_V  = 3'd1;
  localparam logic [2:0] OP_CONS_A  = 3'd2;
  localparam logic [2:0] OP_SELECT  = 3'd3;
  localparam logic [2:0] OP_IGNORE  = 3'd4;

  localparam logic [1:0] KIND_INVALID  = 2'd0;
  localparam logic [1:0] KIND_IGNORE   = 2'd1;
  localparam logic [1:0] KIND_SNAPSHOT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;

  localparam logic [62:0] MAX_DIST_RESET = 63'd167772160000;

endpackage

// ===== hw/rtl/frame_ring_timestamp_selector_core.sv =====
// Frame descriptor ring with put, consume, nearest-timestamp select and ignore walk.
//
// Channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// request  | in_valid / in_ready    | op, frame_type, stamp, frame_index
// result   | out_valid / out_ready  | status, slot, frame_number
// config   | cfg_wr_en              | cfg_wr_data (max_distance)
//
// Put, consume and unused codes are decided on acceptance; the emit state then loads the result register.
// Select walks back from the newest frame over at most RING_SIZE slots: S_SEL_RD reads each slot and
// S_SEL_CMP compares each valid slot, since one shared 64-bit gap and compare unit serves them all.
// Ignore marks slots from the video consume point upward, up to RING_SIZE slots.
// A waiting result does not block the next request; a new result waits until the last is taken.
// Reset clears the counters and marks every slot invalid.
module frame_ring_timestamp_selector_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [1:0]         frame_type,
  input  logic signed [63:0] stamp,
  input  logic signed [31:0] frame_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [3:0]         slot,
  output logic signed [31:0] frame_number,
  input  logic               cfg_wr_en,
  input  logic [62:0]        cfg_wr_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEL_RD  = 3'd1;
  localparam logic [2:0] S_SEL_CMP = 3'd2;
  localparam logic [2:0] S_IGN     = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]  state;
  logic [1:0]  slot_kind [frts_pkg::RING_SIZE];
  logic [63:0] slot_stamp [frts_pkg::RING_SIZE];
  logic [31:0] produced_count;
  logic [31:0] video_consumed;
  logic [31:0] audio_consumed;
  logic [62:0] max_distance;

  logic [31:0] cur_i;
  logic [31:0] low;
  logic [31:0] best;
  logic [63:0] bestdiff;
  logic [63:0] gap;
  logic [63:0] target;
  logic [frts_pkg::CNT_W-1:0] steps;
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic [31:0] res_num;

  logic        accept;
  logic [31:0] dv;
  logic [31:0] da;
  logic        ring_full;
  logic        idx_bad;
  logic [31:0] p_minus1;
  logic [31:0] low_in;
  logic [frts_pkg::SLOT_W-1:0] rd_slot;
  logic [1:0]  rd_kind;
  logic [63:0] rd_stamp;
  logic        stamp_ge;
  logic [31:0] i_minus1;
  logic        sel_more;
  logic        ign_more;
  logic        closer;
  logic        out_free;
  logic        kind_we;
  logic [frts_pkg::SLOT_W-1:0] kind_waddr;
  logic [1:0]  kind_wdata;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign dv        = produced_count - video_consumed;
  assign da        = produced_count - audio_consumed;
  assign ring_full = (dv >= 32'(frts_pkg::RING_SIZE - frts_pkg::HEADROOM)) ||
                     (da >= 32'(frts_pkg::RING_SIZE - frts_pkg::HEADROOM));
  assign idx_bad   = frame_index[31] || (32'(frame_index) >= produced_count);
  assign p_minus1  = produced_count - 32'd1;
  assign low_in    = (video_consumed < audio_consumed) ? video_consumed : audio_consumed;

  assign rd_slot  = cur_i[frts_pkg::SLOT_W-1:0];
  assign rd_kind  = slot_kind[rd_slot];
  assign rd_stamp = slot_stamp[rd_slot];
  assign stamp_ge = $signed(rd_stamp) >= $signed(target);
  assign i_minus1 = cur_i - 32'd1;
  assign sel_more = (steps != frts_pkg::CNT_W'(frts_pkg::RING_SIZE - 1)) &&
                    (cur_i != 32'd0) && (i_minus1 >= low);
  assign ign_more = (steps != frts_pkg::CNT_W'(frts_pkg::RING_SIZE - 1)) &&
                    (({1'b0, cur_i} + 33'd2) < {1'b0, produced_count});
  assign closer   = gap < bestdiff;

  always_comb begin
    kind_we    = 1'b0;
    kind_waddr = rd_slot;
    kind_wdata = frts_pkg::KIND_IGNORE;
    if (accept && op == frts_pkg::OP_PUT && !ring_full) begin
      kind_we    = 1'b1;
      kind_waddr = produced_count[frts_pkg::SLOT_W-1:0];
      kind_wdata = frame_type;
    end else if (state == S_IGN) begin
      kind_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == frts_pkg::OP_PUT && !ring_full) begin
      slot_stamp[produced_count[frts_pkg::SLOT_W-1:0]] <= stamp;
    end
    if (state == S_SEL_RD) begin
      gap <= stamp_ge ? (rd_stamp - target) : (target - rd_stamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_kind      <= '{default: frts_pkg::KIND_INVALID};
      produced_count <= '0;
      video_consumed <= '0;
      audio_consumed <= '0;
      max_distance   <= frts_pkg::MAX_DIST_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_distance <= cfg_wr_data;
      end
      if (kind_we) begin
        slot_kind[kind_waddr] <= kind_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= frts_pkg::ST_OK;
            res_slot   <= '0;
            res_num    <= '0;
            state      <= S_EMIT;
            unique case (op) inside
              frts_pkg::OP_PUT: begin
                res_slot <= 4'(produced_count[frts_pkg::SLOT_W-1:0]);
                res_num  <= produced_count;
                if (ring_full) begin
                  res_status <= frts_pkg::ST_FULL;
                end else begin
                  if (frame_type == frts_pkg::KIND_SNAPSHOT) begin
                    audio_consumed <= produced_count;
                  end
                  produced_count <= produced_count + 32'd1;
                end
              end
              frts_pkg::OP_CONS_V, frts_pkg::OP_CONS_A: begin
                if (idx_bad) begin
                  res_status <= frts_pkg::ST_NO_FRAME;
                  res_num    <= '1;
                end else begin
                  res_slot <= 4'(frame_index[frts_pkg::SLOT_W-1:0]);
                  res_num  <= 32'(frame_index);
                  if (op == frts_pkg::OP_CONS_V) begin
                    video_consumed <= 32'(frame_index);
                  end else begin
                    audio_consumed <= 32'(frame_index);
                  end
                end
              end
              frts_pkg::OP_SELECT: begin
                if (produced_count == 32'd0) begin
                  res_num <= '1;
                end else if (p_minus1 < low_in) begin
                  res_slot <= 4'(p_minus1[frts_pkg::SLOT_W-1:0]);
                  res_num  <= p_minus1;
                end else begin
                  cur_i    <= p_minus1;
                  best     <= p_minus1;
                  low      <= low_in;
                  bestdiff <= {1'b0, max_distance};
                  target   <= stamp;
                  steps    <= '0;
                  state    <= S_SEL_RD;
                end
              end
              frts_pkg::OP_IGNORE: begin
                if (({1'b0, video_consumed} + 33'd1) < {1'b0, produced_count}) begin
                  cur_i <= video_consumed;
                  steps <= '0;
                  state <= S_IGN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEL_RD: begin
          if (rd_kind != frts_pkg::KIND_INVALID && rd_kind != frts_pkg::KIND_IGNORE) begin
            state <= S_SEL_CMP;
          end else if (sel_more) begin
            cur_i <= i_minus1;
            steps <= steps + 1'b1;
          end else begin
            res_slot <= 4'(best[frts_pkg::SLOT_W-1:0]);
            res_num  <= best;
            state    <= S_EMIT;
          end
        end
        S_SEL_CMP: begin
          if (closer) begin
            best     <= cur_i;
            bestdiff <= gap;
          end
          if (closer && sel_more) begin
            cur_i <= i_minus1;
            steps <= steps + 1'b1;
            state <= S_SEL_RD;
          end else begin
            res_slot <= closer ? 4'(cur_i[frts_pkg::SLOT_W-1:0])
                               : 4'(best[frts_pkg::SLOT_W-1:0]);
            res_num  <= closer ? cur_i : best;
            state    <= S_EMIT;
          end
        end
        S_IGN: begin
          cur_i <= cur_i + 32'd1;
          steps <= steps + 1'b1;
          if (!ign_more) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            slot         <= res_slot;
            frame_number <= res_num;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/frts_checker.sv =====
// Port-level checks for the frame ring timestamp selector, bound to the core module.
module frts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [3:0]         slot,
  input logic signed [31:0] frame_number
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot) &&
      $stable(frame_number))
    else $error("result changed while stalled");

  // Every accepted request occupies the sequencer, so in_ready drops after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == frts_pkg::ST_OK || status == frts_pkg::ST_FULL ||
      status == frts_pkg::ST_NO_FRAME)
    else $error("undefined status code");

  a_no_frame_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == frts_pkg::ST_NO_FRAME |-> slot == 4'd0 && frame_number == -32'sd1)
    else $error("missing-frame result not in its fixed form");

  // A full ring refusal names the slot that the frame number maps to.
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == frts_pkg::ST_FULL |-> slot == frame_number[3:0])
    else $error("full result slot does not match frame number");

endmodule

bind frame_ring_timestamp_selector_core frts_checker u_frts_checker (.*);

// ===== tb/frame_ring_timestamp_selector_core_test.sv =====
// Self-checking testbench for the frame ring timestamp selector core.
module frame_ring_timestamp_selector_core_test;
  import frts_pkg::*;

  localparam logic [1:0] KIND_NORMAL = 2'd3;
  localparam int OP_UNUSED_LO = 5;
  localparam int OP_UNUSED_HI = 7;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * RING_SIZE + 8;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 262;
  localparam longint FRAME_TICKS = 559240;
  localparam logic signed [63:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] INDEX_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INDEX_MAX = 32'sh7FFF_FFFF;
  localparam logic [31:0] NO_FRAME_NUMBER = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [31:0] frame_number;
  } frame_result_t;

  class frame_ring_scoreboard;
    logic [1:0] kind[RING_SIZE];
    logic signed [63:0] stamp_of[RING_SIZE];
    logic [31:0] produced;
    logic [31:0] video_at;
    logic [31:0] audio_at;
    logic [62:0] max_distance;
    frame_result_t awaited[$];
    int errors;
    int results_seen;
    int op_count[8];
    int full_count;
    int missing_count;

    function new();
      foreach (kind[k]) begin
        kind[k] = KIND_INVALID;
        stamp_of[k] = '0;
      end
      foreach (op_count[k]) op_count[k] = 0;
      produced = '0;
      video_at = '0;
      audio_at = '0;
      max_distance = MAX_DIST_RESET;
      errors = 0;
      results_seen = 0;
      full_count = 0;
      missing_count = 0;
    endfunction

    function void note_request(input logic [2:0] code, input logic [1:0] kind_in,
                               input logic signed [63:0] when, input logic [31:0] index);
      frame_result_t res;
      logic [31:0] video_gap;
      logic [31:0] audio_gap;
      logic [31:0] low;
      logic [63:0] pos;
      logic [63:0] nearest;
      logic [63:0] best_gap;
      logic [63:0] gap;
      logic [SLOT_W-1:0] s;
      int steps;
      bit done;
      res = '{ST_OK, 4'd0, 32'd0};
      op_count[code]++;
      case (code)
        OP_PUT: begin
          video_gap = produced - video_at;
          audio_gap = produced - audio_at;
          res.slot = produced[SLOT_W-1:0];
          res.frame_number = produced;
          if (video_gap >= RING_SIZE - HEADROOM || audio_gap >= RING_SIZE - HEADROOM) begin
            res.status = ST_FULL;
            full_count++;
          end else begin
            kind[produced[SLOT_W-1:0]] = kind_in;
            stamp_of[produced[SLOT_W-1:0]] = when;
            if (kind_in == KIND_SNAPSHOT) audio_at = produced;
            produced++;
          end
        end
        OP_CONS_V, OP_CONS_A: begin
          if (index[31] || index >= produced) begin
            res = '{ST_NO_FRAME, 4'd0, NO_FRAME_NUMBER};
            missing_count++;
          end else begin
            if (code == OP_CONS_V) video_at = index;
            else audio_at = index;
            res.slot = index[SLOT_W-1:0];
            res.frame_number = index;
          end
        end
        OP_SELECT: begin
          if (produced == 0) begin
            res.frame_number = NO_FRAME_NUMBER;
          end else begin
            low = (video_at < audio_at) ? video_at : audio_at;
            nearest = {32'd0, produced - 32'd1};
            pos = nearest;
            best_gap = {1'b0, max_distance};
            done = 1'b0;
            for (steps = 0; steps < RING_SIZE && !done && pos >= low; steps++) begin
              s = pos[SLOT_W-1:0];
              if (kind[s] != KIND_INVALID && kind[s] != KIND_IGNORE) begin
                gap = (stamp_of[s] >= when) ? stamp_of[s] - when : when - stamp_of[s];
                if (gap < best_gap) begin
                  nearest = pos;
                  best_gap = gap;
                end else begin
                  done = 1'b1;
                end
              end
              if (pos == 0) done = 1'b1;
              else pos--;
            end
            res.slot = nearest[SLOT_W-1:0];
            res.frame_number = nearest[31:0];
          end
        end
        OP_IGNORE: begin
          pos = {32'd0, video_at};
          for (steps = 0; steps < RING_SIZE && pos + 1 < produced; steps++) begin
            kind[pos[SLOT_W-1:0]] = KIND_IGNORE;
            pos++;
          end
        end
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(input logic [1:0] st, input logic [3:0] sl,
                               input logic [31:0] num);
      frame_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: status %0d slot %0d frame %0d",
                   st, sl, $signed(num));
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (st != want.status || sl != want.slot || num != want.frame_number) begin
        if (errors < 10) begin
          $display("result %0d: expected status %0d slot %0d frame %0d",
                   results_seen, want.status, want.slot, $signed(want.frame_number));
          $display("  got status %0d slot %0d frame %0d", st, sl, $signed(num));
        end
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [2:0] op = OP_PUT;
  logic [1:0] frame_type = KIND_INVALID;
  logic signed [63:0] stamp = '0;
  logic signed [31:0] frame_index = '0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [62:0] cfg_wr_data = '0;
  wire in_ready;
  wire out_valid;
  wire [1:0] status;
  wire [3:0] slot;
  wire signed [31:0] frame_number;

  frame_ring_scoreboard sb;
  logic signed [63:0] stream_clock = -64'sd200000000;
  int ready_mode = 0;
  int ready_left = 0;
  int quiet = 0;

  frame_ring_timestamp_selector_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .frame_type(frame_type),
    .stamp(stamp),
    .frame_index(frame_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot(slot),
    .frame_number(frame_number),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, slot, frame_number);
      if (in_valid && in_ready) sb.note_request(op, frame_type, stamp, frame_index);
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(10, 120);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("frame_ring_timestamp_selector_core regression: fail");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] code, input logic [1:0] kind_in,
                              input logic signed [63:0] when, input logic signed [31:0] index);
    in_valid <= 1'b1;
    op <= code;
    frame_type <= kind_in;
    stamp <= when;
    frame_index <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_distance(input logic [62:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    sb.max_distance = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_request;
    int pick;
    int sel;
    int back;
    logic [2:0] code;
    logic [1:0] kind_in;
    logic signed [63:0] when;
    logic signed [31:0] index;
    logic [31:0] head;
    head = sb.produced;
    pick = $urandom_range(0, 99);
    kind_in = 2'($urandom);
    when = {$urandom, $urandom};
    index = $urandom;
    if (pick < 40) begin
      code = OP_PUT;
      sel = $urandom_range(0, 19);
      kind_in = (sel < 2) ? KIND_INVALID : (sel < 4) ? KIND_IGNORE :
                (sel < 6) ? KIND_SNAPSHOT : KIND_NORMAL;
      sel = $urandom_range(0, 99);
      if (sel < 92) begin
        stream_clock = stream_clock + FRAME_TICKS - 150000 + $urandom_range(0, 300000);
        when = stream_clock;
      end else if (sel < 97) begin
        when = stream_clock - longint'($urandom_range(0, 4 * FRAME_TICKS));
      end
    end else if (pick < 70) begin
      code = (pick < 57) ? OP_CONS_V : OP_CONS_A;
      sel = $urandom_range(0, 9);
      back = (sel == 7) ? $urandom_range(4, 14) : $urandom_range(0, 3);
      if (sel <= 7 && head != 0) index = head - 1 - ((back < head) ? back : head - 1);
      else if (sel == 8) index = $urandom | 32'h8000_0000;
      else if ($urandom_range(0, 1) == 0) index = head + $urandom_range(0, 2);
      else index = $urandom & 32'h7FFF_FFFF;
    end else if (pick < 90) begin
      code = OP_SELECT;
      sel = $urandom_range(0, 19);
      if (sel == 1) when = ($urandom_range(0, 1) == 0) ? STAMP_MIN : STAMP_MAX;
      else if (sel > 1)
        when = stream_clock - longint'($urandom_range(0, 16)) * FRAME_TICKS
               + longint'($urandom_range(0, 2 * FRAME_TICKS)) - FRAME_TICKS;
    end else if (pick < 97) begin
      code = OP_IGNORE;
    end else begin
      code = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    send_request(code, kind_in, when, index);
  endtask

  initial begin
    logic [62:0] setting;
    int phase;
    int done_items;
    int burst;
    int k;
    int unused_total;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_SELECT, KIND_INVALID, 64'sd0, 32'sd0);
    send_request(OP_CONS_V, KIND_INVALID, 64'sd0, 32'sd0);
    send_request(OP_CONS_A, KIND_INVALID, 64'sd0, INDEX_MIN);
    send_request(OP_PUT, KIND_NORMAL, STAMP_MIN, 32'sd0);
    send_request(OP_PUT, KIND_NORMAL, STAMP_MAX, 32'sd0);
    send_request(OP_PUT, KIND_INVALID, 64'sd0, 32'sd0);
    send_request(OP_PUT, KIND_IGNORE, 64'sd100, 32'sd0);
    send_request(OP_PUT, KIND_SNAPSHOT, 64'sd1000, 32'sd0);
    send_request(OP_PUT, KIND_NORMAL, 64'sd2000, 32'sd0);
    send_request(OP_SELECT, KIND_INVALID, 64'sd0, 32'sd0);
    send_request(OP_SELECT, KIND_INVALID, STAMP_MIN, 32'sd0);
    send_request(OP_CONS_V, KIND_INVALID, 64'sd0, INDEX_MAX);
    send_request(OP_CONS_A, KIND_INVALID, 64'sd0, 32'sd6);
    send_request(OP_CONS_A, KIND_INVALID, 64'sd0, 32'sd2);
    send_request(OP_IGNORE, KIND_INVALID, 64'sd0, 32'sd0);
    send_request(OP_SELECT, KIND_INVALID, 64'sd1000, 32'sd0);
    for (k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      send_request(3'(k), KIND_NORMAL, STAMP_MAX, INDEX_MIN);
    for (k = 0; k < 7; k++)
      send_request(OP_PUT, KIND_NORMAL, 64'sd3000 + 64'(k * 1000), 32'sd0);

    for (phase = 1; phase <= PHASES; phase++) begin
      wait_drained;
      case (phase)
        1: setting = '0;
        2: setting = '1;
        3: setting = 63'($urandom_range(1, 3 * FRAME_TICKS));
        4: setting = MAX_DIST_RESET;
        5: setting = 63'({$urandom, $urandom});
        6: setting = 63'(FRAME_TICKS);
        default: setting = 63'd1;
      endcase
      write_max_distance(setting);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 30);
        while (burst > 0 && done_items < ITEMS_PER_PHASE) begin
          send_random_request();
          burst--;
          done_items++;
        end
        if ($urandom_range(0, 29) == 0) wait_drained;
        else pause_sender($urandom_range(1, 8));
      end
    end

    wait_drained;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $display("%0d expected results never arrived", sb.awaited.size());
      sb.errors += sb.awaited.size();
    end
    unused_total = 0;
    for (k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      unused_total += sb.op_count[k];
    $write("Ran %0d puts (%0d refused as full), ", sb.op_count[OP_PUT], sb.full_count);
    $write("%0d consumes (%0d without a frame), ",
           sb.op_count[OP_CONS_V] + sb.op_count[OP_CONS_A], sb.missing_count);
    $display("%0d selects, %0d ignores and %0d unused codes.",
             sb.op_count[OP_SELECT], sb.op_count[OP_IGNORE], unused_total);
    $display("Checked %0d results over %0d max_distance settings, including zero and all ones.",
             sb.results_seen, PHASES + 1);
    if (sb.errors == 0) begin
      $display("frame_ring_timestamp_selector_core regression: pass");
    end else begin
      $display("frame_ring_timestamp_selector_core regression: fail");
    end
    $finish;
  end

endmodule
